### sv/tsd_pkg.sv
// shared constants and types for the trimmed sum block
// no dependencies; used by the interfaces and the top level
package tsd_pkg;

  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 42;
  localparam int STATUS_W = 2;
  localparam int EXTREMES = 3;
  // six 32-bit extremes fit in 35 bits
  localparam int DROP_W   = SAMPLE_W + 3;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SKIP_COUNT_DEF  = 2;

  localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

endpackage

### sv/tsd_in_if.sv
// input channel of the trimmed sum block: one sample per item
// depends on tsd_pkg
interface tsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsd_pkg::SAMPLE_W-1:0]  sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

### sv/tsd_out_if.sv
// result channel of the trimmed sum block: one result per batch
// depends on tsd_pkg
interface tsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsd_pkg::SUM_W-1:0]     trimmed_sum;
  logic [tsd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output trimmed_sum, output status, input ready);
  modport sink   (input valid, input trimmed_sum, input status, output ready);
endinterface

### sv/trimmed_sum_drop_three_extremes.sv
// Trimmed sum of a sample batch, three smallest and three largest dropped.
//
// in_i carries one 32-bit unsigned sample per item, last marks the end of a
// batch. The first SKIP_COUNT samples of each batch are discarded; every
// later sample is added to a saturating 42-bit total and sorted into two
// three-entry registers of smallest and largest values.
// out_o gives one result per batch: total minus the six extremes (zero for a short
// batch, all ones when saturated) and a status (ok, fewer than six kept samples, total saturated).
// Throughput: one item per cycle while in_i.ready is high, set by the combinational
// compare/insert and add on the batch accumulator.
// Pipeline: the edge that accepts the last sample of a batch loads the snapshot
// stage; the result then passes the extreme-sum stage and is subtracted into
// the output register, where it is presented until taken.
// Reset clears the accumulator and empties the pipeline; the block accepts
// items from the first cycle after reset.
// When the receiver stalls, results stay in the pipeline registers and
// in_i.ready drops only once a finished batch can no longer move forward.
// Depends on tsd_pkg, tsd_in_if and tsd_out_if.
module trimmed_sum_drop_three_extremes #(
  parameter int MAX_SAMPLES = tsd_pkg::MAX_SAMPLES_DEF,
  parameter int SKIP_COUNT  = tsd_pkg::SKIP_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tsd_in_if.sink           in_i,
  tsd_out_if.source        out_o
);

  localparam int SAMPLE_W = tsd_pkg::SAMPLE_W;
  localparam int SUM_W    = tsd_pkg::SUM_W;
  localparam int DROP_W   = tsd_pkg::DROP_W;
  localparam int EXT      = tsd_pkg::EXTREMES;
  localparam int POS_CAP  = MAX_SAMPLES + SKIP_COUNT;
  localparam int POS_W    = $clog2(POS_CAP + 1);
  localparam int SHORT_LIM = SKIP_COUNT + 2 * EXT;

  localparam logic [POS_W-1:0] POS_CAP_V   = POS_W'(POS_CAP);
  localparam logic [POS_W-1:0] SKIP_V      = POS_W'(SKIP_COUNT);
  localparam logic [POS_W-1:0] SHORT_LIM_V = POS_W'(SHORT_LIM);

  // batch accumulator
  logic [SUM_W-1:0]    total_q, total_d;
  logic [SAMPLE_W-1:0] small_q [EXT];
  logic [SAMPLE_W-1:0] small_d [EXT];
  logic [SAMPLE_W-1:0] large_q [EXT];
  logic [SAMPLE_W-1:0] large_d [EXT];
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                sat_q, sat_d;
  logic [SUM_W:0]      sum_ext;
  logic [SAMPLE_W-1:0] x;

  // snapshot stage
  logic                fin_valid_q;
  logic [SUM_W-1:0]    fin_total_q;
  logic [SAMPLE_W-1:0] fin_small_q [EXT];
  logic [SAMPLE_W-1:0] fin_large_q [EXT];
  logic                fin_short_q;
  logic                fin_sat_q;

  // extreme-sum stage
  logic                drp_valid_q;
  logic [SUM_W-1:0]    drp_total_q;
  logic [DROP_W-1:0]   drp_drop_q, drop_d;
  logic                drp_short_q;
  logic                drp_sat_q;

  // output register
  logic                out_valid_q;
  logic [SUM_W-1:0]    out_sum_q, out_sum_d;
  tsd_pkg::status_e    out_status_q, out_status_d;
  logic [SUM_W-1:0]    drop_ext;

  logic out_adv, drp_adv, fin_adv, in_fire;

  assign out_adv = !out_valid_q || out_o.ready;
  assign drp_adv = !drp_valid_q || out_adv;
  assign fin_adv = !fin_valid_q || drp_adv;
  assign in_i.ready = fin_adv;
  assign in_fire = in_i.valid && fin_adv;
  assign x = in_i.sample;

  // compare/insert and saturating add for one sample
  always_comb begin
    total_d = total_q;
    small_d = small_q;
    large_d = large_q;
    sat_d   = sat_q;
    pos_d   = pos_q;
    sum_ext = {1'b0, total_q} + (SUM_W + 1)'(x);
    if (pos_q >= SKIP_V) begin
      if (sum_ext[SUM_W]) begin
        total_d = tsd_pkg::SUM_MAX;
        sat_d   = 1'b1;
      end else begin
        total_d = sum_ext[SUM_W-1:0];
      end
      // smallest kept ascending
      if (x < small_q[0]) begin
        small_d = '{x, small_q[0], small_q[1]};
      end else if (x < small_q[1]) begin
        small_d = '{small_q[0], x, small_q[1]};
      end else if (x < small_q[2]) begin
        small_d = '{small_q[0], small_q[1], x};
      end
      // largest kept descending
      if (x > large_q[0]) begin
        large_d = '{x, large_q[0], large_q[1]};
      end else if (x > large_q[1]) begin
        large_d = '{large_q[0], x, large_q[1]};
      end else if (x > large_q[2]) begin
        large_d = '{large_q[0], large_q[1], x};
      end
    end
    if (pos_q < POS_CAP_V) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      small_q <= '{default: tsd_pkg::SAMPLE_MAX};
      large_q <= '{default: '0};
      pos_q   <= '0;
      sat_q   <= 1'b0;
    end else if (in_fire) begin
      if (in_i.last) begin
        // batch closes, accumulator back to its empty state
        total_q <= '0;
        small_q <= '{default: tsd_pkg::SAMPLE_MAX};
        large_q <= '{default: '0};
        pos_q   <= '0;
        sat_q   <= 1'b0;
      end else begin
        total_q <= total_d;
        small_q <= small_d;
        large_q <= large_d;
        pos_q   <= pos_d;
        sat_q   <= sat_d;
      end
    end
  end

  // valid bits of the result pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      drp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_adv) begin
        fin_valid_q <= in_fire && in_i.last;
      end
      if (drp_adv) begin
        drp_valid_q <= fin_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= drp_valid_q;
      end
    end
  end

  always_comb begin
    drop_d = '0;
    for (int k = 0; k < EXT; k++) begin
      drop_d = drop_d + DROP_W'(fin_small_q[k]) + DROP_W'(fin_large_q[k]);
    end
  end

  assign drop_ext = SUM_W'(drp_drop_q);

  always_comb begin
    if (drp_short_q) begin
      out_sum_d    = '0;
      out_status_d = tsd_pkg::ST_SHORT;
    end else if (drp_sat_q) begin
      out_sum_d    = tsd_pkg::SUM_MAX;
      out_status_d = tsd_pkg::ST_SAT;
    end else begin
      out_sum_d    = (drp_total_q >= drop_ext) ? drp_total_q - drop_ext : '0;
      out_status_d = tsd_pkg::ST_OK;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.last) begin
      fin_total_q <= total_d;
      fin_small_q <= small_d;
      fin_large_q <= large_d;
      fin_sat_q   <= sat_d;
      fin_short_q <= pos_d < SHORT_LIM_V;
    end
    if (fin_valid_q && drp_adv) begin
      drp_total_q <= fin_total_q;
      drp_drop_q  <= drop_d;
      drp_short_q <= fin_short_q;
      drp_sat_q   <= fin_sat_q;
    end
    if (drp_valid_q && out_adv) begin
      out_sum_q    <= out_sum_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.trimmed_sum = out_sum_q;
  assign out_o.status      = out_status_q;

  // extreme registers stay sorted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    small_q[0] <= small_q[1] && small_q[1] <= small_q[2] &&
    large_q[0] >= large_q[1] && large_q[1] >= large_q[2])
    else $error("extreme registers out of order");

  // a closing sample empties the accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.last |=> pos_q == '0 && total_q == '0 && !sat_q)
    else $error("accumulator not cleared after last sample");

  // position counter never passes its cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_CAP_V)
    else $error("position counter above cap");

  // a short batch reports a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == tsd_pkg::ST_SHORT |-> out_sum_q == '0)
    else $error("short batch with nonzero sum");

endmodule

### verif/tb_trimmed_sum_drop_three_extremes.sv
// testbench for trimmed_sum_drop_three_extremes: directed batches, then random batches
// results are checked against an in-bench model of the trimmed sum, or against table values for typed directed rows
// depends on tsd_pkg, tsd_in_if, tsd_out_if and the top level
`timescale 1ns / 1ps

module tb_trimmed_sum_drop_three_extremes;

  localparam int POS_CAP     = tsd_pkg::MAX_SAMPLES_DEF + tsd_pkg::SKIP_COUNT_DEF;
  localparam int ITEM_TARGET = 1450;
  localparam int MIN_BATCHES = 30;
  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR       = 25;

  typedef struct packed {
    logic [tsd_pkg::SUM_W-1:0] sum;
    tsd_pkg::status_e          status;
  } trim_result_t;

  typedef struct packed {
    logic [tsd_pkg::SAMPLE_W-1:0] smp;
    logic                         lst;
    logic                         typed;
    logic [tsd_pkg::SUM_W-1:0]    sum;
    tsd_pkg::status_e             status;
  } dir_row_t;

  typedef enum int {
    FILL_FULL,
    FILL_LOW,
    FILL_HIGH,
    FILL_EDGE
  } fill_e;

  logic clk_i;
  logic rst_ni;

  tsd_in_if  in_ch ();
  tsd_out_if out_ch ();

  trimmed_sum_drop_three_extremes dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // batch model state
  logic [tsd_pkg::SUM_W-1:0]    acc_total;
  logic [tsd_pkg::SAMPLE_W-1:0] low3 [tsd_pkg::EXTREMES];
  logic [tsd_pkg::SAMPLE_W-1:0] high3 [tsd_pkg::EXTREMES];
  logic [10:0]                  pos_cnt;
  logic                         acc_sat;

  trim_result_t expected_sums [$];
  int           mismatch_cnt;
  int           sent_items;
  int           cycle_cnt;

  // short batches, all-extreme batch, duplicate-heavy batch
  dir_row_t dir_rows [N_DIR] = '{
    '{32'd5,               1'b1, 1'b1, '0, tsd_pkg::ST_SHORT},
    '{tsd_pkg::SAMPLE_MAX, 1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd0,               1'b1, 1'b1, '0, tsd_pkg::ST_SHORT},
    '{32'd1,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd2,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{tsd_pkg::SAMPLE_MAX, 1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd0,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd3,               1'b1, 1'b1, '0, tsd_pkg::ST_SHORT},
    '{tsd_pkg::SAMPLE_MAX, 1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd0,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd0,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{tsd_pkg::SAMPLE_MAX, 1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd0,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{tsd_pkg::SAMPLE_MAX, 1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd0,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{tsd_pkg::SAMPLE_MAX, 1'b1, 1'b1, '0, tsd_pkg::ST_OK},
    '{32'd9,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd9,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd7,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd7,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd100,             1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd42,              1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd7,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd7,               1'b0, 1'b0, '0, tsd_pkg::ST_OK},
    '{32'd7,               1'b1, 1'b0, '0, tsd_pkg::ST_OK}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void clear_batch();
    acc_total = '0;
    for (int k = 0; k < tsd_pkg::EXTREMES; k++) begin
      low3[k]  = tsd_pkg::SAMPLE_MAX;
      high3[k] = '0;
    end
    pos_cnt = '0;
    acc_sat = 1'b0;
  endfunction

  // returns 1 when the sample closes a batch, with the expected result in r
  function automatic bit predict_trimmed_sum(input logic [tsd_pkg::SAMPLE_W-1:0] x,
                                             input logic lst, output trim_result_t r);
    logic [tsd_pkg::SUM_W:0] t;
    logic [tsd_pkg::SUM_W:0] drop;
    int                      k;
    int                      kept;
    r = '0;
    if (pos_cnt >= tsd_pkg::SKIP_COUNT_DEF) begin
      t = {1'b0, acc_total} + x;
      if (t > tsd_pkg::SUM_MAX) begin
        t = tsd_pkg::SUM_MAX;
        acc_sat = 1'b1;
      end
      acc_total = t[tsd_pkg::SUM_W-1:0];
      if (x < low3[tsd_pkg::EXTREMES-1]) begin
        k = tsd_pkg::EXTREMES - 1;
        while (k > 0 && x < low3[k-1]) begin
          low3[k] = low3[k-1];
          k--;
        end
        low3[k] = x;
      end
      if (x > high3[tsd_pkg::EXTREMES-1]) begin
        k = tsd_pkg::EXTREMES - 1;
        while (k > 0 && x > high3[k-1]) begin
          high3[k] = high3[k-1];
          k--;
        end
        high3[k] = x;
      end
    end
    if (pos_cnt < POS_CAP) pos_cnt++;
    if (!lst) return 1'b0;
    kept = (pos_cnt > tsd_pkg::SKIP_COUNT_DEF) ?
           int'(pos_cnt) - tsd_pkg::SKIP_COUNT_DEF : 0;
    if (kept < 2 * tsd_pkg::EXTREMES) begin
      r.sum    = '0;
      r.status = tsd_pkg::ST_SHORT;
    end else if (acc_sat) begin
      r.sum    = tsd_pkg::SUM_MAX;
      r.status = tsd_pkg::ST_SAT;
    end else begin
      drop = '0;
      for (k = 0; k < tsd_pkg::EXTREMES; k++) drop = drop + low3[k] + high3[k];
      r.sum    = ({1'b0, acc_total} >= drop) ?
                 acc_total - drop[tsd_pkg::SUM_W-1:0] : '0;
      r.status = tsd_pkg::ST_OK;
    end
    clear_batch();
    return 1'b1;
  endfunction

  function automatic logic [tsd_pkg::SAMPLE_W-1:0] pick_sample(input fill_e fill);
    logic [tsd_pkg::SAMPLE_W-1:0] v;
    case (fill)
      FILL_FULL: v = $urandom;
      FILL_LOW:  v = $urandom_range(0, 15);
      FILL_HIGH: v = tsd_pkg::SAMPLE_MAX - $urandom_range(0, 15);
      default: begin
        case ($urandom_range(0, 2))
          0:       v = '0;
          1:       v = tsd_pkg::SAMPLE_MAX;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic [tsd_pkg::SAMPLE_W-1:0] smp, input logic lst,
                             input bit quiet, input bit typed,
                             input trim_result_t typed_res);
    int           gap;
    trim_result_t res;
    gap = quiet ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid  = 1'b1;
    in_ch.sample = smp;
    in_ch.last   = lst;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_items++;
    if (predict_trimmed_sum(smp, lst, res)) expected_sums.push_back(typed ? typed_res : res);
  endtask

  // hold the input idle until every pending result has been taken
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, compare each accepted item with the oldest expectation
  initial begin
    int           stall;
    bit           rx_quiet;
    trim_result_t want;
    out_ch.ready = 1'b0;
    rx_quiet     = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk_i);
        out_ch.ready = 1'b0;
      end
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (expected_sums.size() == 0) begin
        $error("unexpected result: trimmed_sum %0d status %0d", out_ch.trimmed_sum,
               out_ch.status);
        mismatch_cnt++;
      end else begin
        want = expected_sums.pop_front();
        if (out_ch.trimmed_sum !== want.sum) begin
          $error("trimmed_sum: expected %0d, got %0d", want.sum, out_ch.trimmed_sum);
          mismatch_cnt++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int    len;
    int    long_at;
    int    batch_idx;
    int    kind;
    bit    quiet;
    fill_e fill;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    mismatch_cnt = 0;
    sent_items   = 0;
    cycle_cnt    = 0;
    clear_batch();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_sample(dir_rows[i].smp, dir_rows[i].lst, 1'b0, dir_rows[i].typed,
                  '{sum: dir_rows[i].sum, status: dir_rows[i].status});
    end
    wait_results_drained();

    // mostly well-formed batches; one batch runs past the position cap and saturates
    long_at   = $urandom_range(3, 20);
    batch_idx = 0;
    while (sent_items < ITEM_TARGET || batch_idx < MIN_BATCHES) begin
      quiet = ($urandom_range(0, 3) == 0);
      fill  = fill_e'($urandom_range(0, 3));
      kind  = $urandom_range(0, 9);
      if (batch_idx == long_at) begin
        wait_results_drained();
        len  = POS_CAP + 1 + $urandom_range(0, 12);
        fill = FILL_HIGH;
      end else if (kind == 0) begin
        len = $urandom_range(1, 2);
      end else if (kind == 1) begin
        len = $urandom_range(3, 7);
      end else begin
        len = $urandom_range(8, 20);
      end
      for (int i = 0; i < len; i++) begin
        send_sample(pick_sample(fill), (i == len - 1), quiet, 1'b0, '0);
      end
      batch_idx++;
    end

    wait_results_drained();
    repeat (4 * LATENCY) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
sv/tsd_pkg.sv
sv/tsd_in_if.sv
sv/tsd_out_if.sv
sv/trimmed_sum_drop_three_extremes.sv
verif/tb_trimmed_sum_drop_three_extremes.sv
